@@ rtl/dual_axis_pd_motion_controller_top_assert.svh @@
// Assertion macros shared by the motion controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DUAL_AXIS_PD_MOTION_CONTROLLER_TOP_ASSERT_SVH
`define DUAL_AXIS_PD_MOTION_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define DAPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define DAPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dapd_pkg.sv @@
// Shared types and constants of the dual-axis PD motion controller.
// No dependencies; used by dapd_csr, dapd_pd and the top level.
package dapd_pkg;

   localparam int FRAC_BITS = 12;

   // selector codes on the request side
   localparam logic [1:0] OP_DISTANCE = 2'd0;
   localparam logic [1:0] OP_STEER    = 2'd1;
   localparam logic [1:0] OP_SPIN     = 2'd2;

   // motor command codes on the response side
   localparam logic [2:0] CMD_NONE     = 3'd0;
   localparam logic [2:0] CMD_FORWARD  = 3'd1;
   localparam logic [2:0] CMD_BACKWARD = 3'd2;
   localparam logic [2:0] CMD_LEFT     = 3'd3;
   localparam logic [2:0] CMD_RIGHT    = 3'd4;
   localparam logic [2:0] CMD_STOP     = 3'd5;

   // register indexes
   localparam logic [2:0] REG_TARGET_ANGLE        = 3'd0;
   localparam logic [2:0] REG_TARGET_DISTANCE     = 3'd1;
   localparam logic [2:0] REG_ANGLE_KP            = 3'd2;
   localparam logic [2:0] REG_ANGLE_KD            = 3'd3;
   localparam logic [2:0] REG_DISTANCE_KP         = 3'd4;
   localparam logic [2:0] REG_DISTANCE_KD         = 3'd5;
   localparam logic [2:0] REG_MAX_LINEAR_SPEED    = 3'd6;
   localparam logic [2:0] REG_MAX_SPIN_CORRECTION = 3'd7;

   localparam logic [15:0] LATCHED_GAIN   = 16'd1280;  // 5.0 in Q8.8
   localparam logic [6:0]  PCT_MAX        = 7'd100;
   localparam logic [14:0] TARGET_DIST_RST = 15'd320;

   typedef struct packed {
      logic signed [15:0] target_angle;
      logic [14:0]        target_distance;
      logic [15:0]        angle_kp;
      logic [15:0]        angle_kd;
      logic [15:0]        distance_kp;
      logic [15:0]        distance_kd;
      logic [6:0]         max_linear_speed;
      logic [6:0]         max_spin_correction;
   } cfg_type;

   // operands of one PD evaluation
   typedef struct packed {
      logic [15:0]        kp;
      logic [15:0]        kd;
      logic signed [16:0] err;
      logic signed [16:0] prev;
      logic [6:0]         lim;
   } pd_req_type;

endpackage

@@ rtl/dapd_csr.sv @@
// Configuration register file of the motion controller.
// Depends on dapd_pkg for the register indexes and the cfg_type struct.
module dapd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [15:0]       csr_wdata,
   output dapd_pkg::cfg_type cfg
);

   dapd_pkg::cfg_type cfg_ff;
   dapd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            dapd_pkg::REG_TARGET_ANGLE:        cfg_in.target_angle = $signed(csr_wdata);
            dapd_pkg::REG_TARGET_DISTANCE:     cfg_in.target_distance = csr_wdata[14:0];
            dapd_pkg::REG_ANGLE_KP:            cfg_in.angle_kp = csr_wdata;
            dapd_pkg::REG_ANGLE_KD:            cfg_in.angle_kd = csr_wdata;
            dapd_pkg::REG_DISTANCE_KP:         cfg_in.distance_kp = csr_wdata;
            dapd_pkg::REG_DISTANCE_KD:         cfg_in.distance_kd = csr_wdata;
            dapd_pkg::REG_MAX_LINEAR_SPEED:    cfg_in.max_linear_speed = csr_wdata[6:0];
            dapd_pkg::REG_MAX_SPIN_CORRECTION: cfg_in.max_spin_correction = csr_wdata[6:0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle        <= '0;
         cfg_ff.target_distance     <= dapd_pkg::TARGET_DIST_RST;
         cfg_ff.angle_kp            <= '0;
         cfg_ff.angle_kd            <= '0;
         cfg_ff.distance_kp         <= '0;
         cfg_ff.distance_kd         <= '0;
         cfg_ff.max_linear_speed    <= dapd_pkg::PCT_MAX;
         cfg_ff.max_spin_correction <= dapd_pkg::PCT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/dapd_pd.sv @@
// PD evaluation: kp*e + kd*(e - prev) at Q.12, clamp, truncate to percent.
// Depends on dapd_pkg for pd_req_type and the fixed-point constants.
module dapd_pd (
   input  dapd_pkg::pd_req_type req,
   output logic signed [7:0]    pct
);

   logic signed [17:0] diff;
   logic signed [33:0] p_prod;
   logic signed [34:0] d_prod;
   logic signed [35:0] sum;
   logic [6:0]         lim_c;
   logic signed [35:0] lim_q;
   logic signed [19:0] clamped;
   logic signed [19:0] biased;

   always_comb begin
      diff   = $signed({req.err[16], req.err}) - $signed({req.prev[16], req.prev});
      p_prod = $signed({1'b0, req.kp}) * req.err;
      d_prod = $signed({1'b0, req.kd}) * diff;
      sum    = 36'(p_prod) + 36'(d_prod);

      // limits above 100 percent act as 100
      lim_c = (req.lim > dapd_pkg::PCT_MAX) ? dapd_pkg::PCT_MAX : req.lim;
      lim_q = $signed({17'd0, lim_c, 12'd0});

      if (sum > lim_q) begin
         clamped = lim_q[19:0];
      end else if (sum < -lim_q) begin
         clamped = 20'(-lim_q);
      end else begin
         clamped = sum[19:0];
      end

      // round toward zero: bias negatives before the arithmetic shift
      biased = clamped + (clamped[19] ? 20'sd4095 : 20'sd0);
      pct    = biased[19:dapd_pkg::FRAC_BITS];
   end

endmodule

@@ rtl/dual_axis_pd_motion_controller_top.sv @@
// Top level of the dual-axis PD motion controller: handshake, state, command decode.
// Depends on dapd_pkg, dapd_csr, dapd_pd and the shared assertion header.
//
//  channel | ports              | word
//  --------+--------------------+---------------------------------------------------
//  req     | req_tvalid/tready  | tuser[1:0] op, tdata[15:0] measurement
//  rsp     | rsp_tvalid/tready  | tuser[2:0] motor_cmd, tdata speeds and on_target
//  csr     | csr_we             | csr_addr register index, csr_wdata value
//
// One word per cycle sustained while rsp is not stalled; each word is held in
// the input register, then in the result register that drives rsp.
// The path from the input register to the result register holds one PD unit
// (two parallel multipliers, add, clamp) followed by the motor mixing.
// Reset is synchronous, active high; it restores register defaults and clears
// the loop state. A stall on rsp holds the result register and backs up into
// the input register; req_tready drops only when both are full.
`include "dual_axis_pd_motion_controller_top_assert.svh"

module dual_axis_pd_motion_controller_top #(
   parameter int ANGLE_DEAD_BAND    = 3,
   parameter int DISTANCE_DEAD_BAND = 2,
   parameter int STEER_DEAD_BAND    = 3
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] measurement
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] speed_first, [13:7] speed_second,
                                    // [14] on_target, [15] zero
   output logic [2:0]  rsp_tuser,   // [2:0] motor_cmd
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // dead bands compared as |error| < band * 16 (Q12.4)
   localparam logic [16:0] ANGLE_BAND_Q    = 17'(ANGLE_DEAD_BAND * 16);
   localparam logic [16:0] DISTANCE_BAND_Q = 17'(DISTANCE_DEAD_BAND * 16);
   localparam logic [16:0] STEER_BAND_Q    = 17'(STEER_DEAD_BAND * 16);

   dapd_pkg::cfg_type    cfg;
   dapd_pkg::pd_req_type pd_req;
   logic signed [7:0]    pct;

   // input register
   logic               s1_valid_ff;
   logic [1:0]         s1_op_ff;
   logic signed [15:0] s1_meas_ff;
   logic               req_fire;
   logic               advance;

   // loop state
   logic signed [16:0] last_dist_err_ff, last_dist_err_in;
   logic signed [16:0] last_ang_err_ff,  last_ang_err_in;
   logic signed [7:0]  linear_speed_ff,  linear_speed_in;
   logic               latched_ff,       latched_in;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         cmd_ff, cmd_in;
   logic [6:0]         spd_a_ff, spd_a_in;
   logic [6:0]         spd_b_ff, spd_b_in;
   logic               on_ff, on_in;

   // datapath
   logic signed [16:0] dist_err;
   logic signed [16:0] ang_err;
   logic [16:0]        dist_mag;
   logic [16:0]        ang_mag;
   logic               latch_now;
   logic signed [7:0]  dist_spd;
   logic signed [7:0]  neg_spd;
   logic signed [7:0]  right_spd;
   logic signed [7:0]  left_spd;
   logic signed [7:0]  neg_right;
   logic signed [7:0]  neg_left;
   logic signed [7:0]  neg_pct;

   // saturate a steering sum to +-100
   function automatic logic signed [7:0] sat_pct(input logic signed [8:0] v);
      logic signed [8:0] hi;
      hi = 9'sd100;
      if (v > hi) begin
         sat_pct = 8'sd100;
      end else if (v < -hi) begin
         sat_pct = -8'sd100;
      end else begin
         sat_pct = v[7:0];
      end
   endfunction

   dapd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dapd_pd u_pd (
      .req (pd_req),
      .pct (pct)
   );

   // move the held word on when the result register is empty or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      dist_err  = $signed({s1_meas_ff[15], s1_meas_ff}) -
                  $signed({2'b00, cfg.target_distance});
      ang_err   = $signed({cfg.target_angle[15], cfg.target_angle}) -
                  $signed({s1_meas_ff[15], s1_meas_ff});
      dist_mag  = dist_err[16] ? 17'(-dist_err) : dist_err;
      ang_mag   = ang_err[16]  ? 17'(-ang_err)  : ang_err;
      // a negative distance error switches to the fixed gains for good
      latch_now = latched_ff || dist_err[16];

      // select operands for the shared PD unit
      case (s1_op_ff)
         dapd_pkg::OP_DISTANCE: begin
            pd_req.kp   = latch_now ? dapd_pkg::LATCHED_GAIN : cfg.distance_kp;
            pd_req.kd   = latch_now ? dapd_pkg::LATCHED_GAIN : cfg.distance_kd;
            pd_req.err  = dist_err;
            pd_req.prev = last_dist_err_ff;
            pd_req.lim  = cfg.max_linear_speed;
         end
         dapd_pkg::OP_STEER: begin
            pd_req.kp   = cfg.angle_kp;
            pd_req.kd   = cfg.angle_kd;
            pd_req.err  = ang_err;
            pd_req.prev = last_ang_err_ff;
            pd_req.lim  = dapd_pkg::PCT_MAX;
         end
         default: begin
            pd_req.kp   = cfg.angle_kp;
            pd_req.kd   = cfg.angle_kd;
            pd_req.err  = ang_err;
            pd_req.prev = last_ang_err_ff;
            pd_req.lim  = cfg.max_spin_correction;
         end
      endcase

      // distance: zero inside dead band
      dist_spd = (dist_mag < DISTANCE_BAND_Q) ? 8'sd0 : pct;
      neg_spd  = -dist_spd;

      // steering: split kept speed across the two motors
      right_spd = sat_pct(9'(linear_speed_ff) + 9'(pct));
      left_spd  = sat_pct(9'(linear_speed_ff) - 9'(pct));
      if (ang_mag < STEER_BAND_Q) begin
         right_spd = 8'sd0;
         left_spd  = 8'sd0;
      end
      neg_right = -right_spd;
      neg_left  = -left_spd;
      neg_pct   = -pct;

      // hold state unless this word updates it
      last_dist_err_in = last_dist_err_ff;
      last_ang_err_in  = last_ang_err_ff;
      linear_speed_in  = linear_speed_ff;
      latched_in       = latched_ff;

      cmd_in   = dapd_pkg::CMD_NONE;
      spd_a_in = '0;
      spd_b_in = '0;
      on_in    = 1'b0;

      case (s1_op_ff)
         dapd_pkg::OP_DISTANCE: begin
            last_dist_err_in = dist_err;
            linear_speed_in  = dist_spd;
            latched_in       = latch_now;
            if (dist_spd > 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_FORWARD;
               spd_a_in = dist_spd[6:0];
               spd_b_in = dist_spd[6:0];
            end else if (dist_spd < 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_BACKWARD;
               spd_a_in = neg_spd[6:0];
               spd_b_in = neg_spd[6:0];
            end else begin
               cmd_in = dapd_pkg::CMD_STOP;
            end
         end
         dapd_pkg::OP_STEER: begin
            last_ang_err_in = ang_err;
            if (right_spd > 8'sd0 && left_spd > 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_FORWARD;
               spd_a_in = right_spd[6:0];
               spd_b_in = left_spd[6:0];
            end else if (right_spd < 8'sd0 && left_spd < 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_BACKWARD;
               spd_a_in = neg_right[6:0];
               spd_b_in = neg_left[6:0];
            end else if (right_spd > 8'sd0 && left_spd < 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_LEFT;
               spd_a_in = right_spd[6:0];
               spd_b_in = neg_left[6:0];
            end else if (right_spd < 8'sd0 && left_spd > 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_RIGHT;
               spd_a_in = left_spd[6:0];
               spd_b_in = neg_right[6:0];
            end
         end
         dapd_pkg::OP_SPIN: begin
            last_ang_err_in = ang_err;
            on_in           = (ang_mag < ANGLE_BAND_Q);
            if (pct > 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_RIGHT;
               spd_a_in = pct[6:0];
               spd_b_in = pct[6:0];
            end else if (pct < 8'sd0) begin
               cmd_in   = dapd_pkg::CMD_LEFT;
               spd_a_in = neg_pct[6:0];
               spd_b_in = neg_pct[6:0];
            end
         end
         default: begin
            // unknown selector: all-zero word, no state change
            cmd_in = dapd_pkg::CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_dist_err_ff <= '0;
         last_ang_err_ff  <= '0;
         linear_speed_ff  <= '0;
         latched_ff       <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff     <= 1'b1;
            last_dist_err_ff <= last_dist_err_in;
            last_ang_err_ff  <= last_ang_err_in;
            linear_speed_ff  <= linear_speed_in;
            latched_ff       <= latched_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_meas_ff <= $signed(req_tdata);
      end
      if (advance) begin
         cmd_ff   <= cmd_in;
         spd_a_ff <= spd_a_in;
         spd_b_ff <= spd_b_in;
         on_ff    <= on_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tdata  = {1'b0, on_ff, spd_b_ff, spd_a_ff};

   `DAPD_ASSERT_NEXT(a_latch_sticks, clock, reset, latched_ff, latched_ff, "gain latch cleared")
   `DAPD_ASSERT_IMPLY(a_speed_range, clock, reset, 1'b1,
      (linear_speed_ff <= 8'sd100) && (linear_speed_ff >= -8'sd100), "kept speed out of range")
   `DAPD_ASSERT_IMPLY(a_idle_cmd_zero, clock, reset,
      rsp_tvalid && (rsp_tuser == dapd_pkg::CMD_NONE || rsp_tuser == dapd_pkg::CMD_STOP),
      rsp_tdata[13:0] == 14'd0, "idle command with nonzero speed")
   `DAPD_ASSERT_IMPLY(a_rsp_speed_max, clock, reset, rsp_tvalid,
      (rsp_tdata[6:0] <= 7'd100) && (rsp_tdata[13:7] <= 7'd100), "speed above 100")
   `DAPD_ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_tvalid, "result lost")

endmodule
